[hdl/bda_pkg.sv]
// Package for the binary to decimal ASCII converter.
// Holds the sizing constants and the sequencer state type; no dependencies.

package bda_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned BCD_BITS   = 4 * MAX_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned REM_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CHAR_W     = 6;

  // High two bits of ASCII '0' in the six-bit character field.
  localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

[hdl/binary_to_decimal_ascii_core.sv]
// Top level of the binary to decimal ASCII converter.
// Double-dabble shift unit, sequencer and output register; uses bda_pkg.
//
// Usage:
//   Input channel: value_i with in_valid_i; the block raises in_stall_o
//   from the cycle after an item is accepted until the done state that follows
//   the hand-over of its last digit to the output register has passed. An
//   item is taken when in_valid_i is high and in_stall_o is low.
//   Output channel: one item per decimal digit, most significant first,
//   with no leading zeros (zero gives a single '0'). last_o marks the least
//   significant digit. An item leaves when out_valid_o is high and
//   out_stall_i is low.
//   Conversion: one shift-and-adjust step per input bit, then one step per
//   digit of the register; leading zeros also take a step each to drop. So
//   with no output stall the time per item does not depend on the value, and
//   a new item is only taken once the previous one has passed the done state.
//   A stalled output holds its digit; the sequencer waits in the digit phase
//   until the output register frees up.
//   Reset clears the sequencer and the output valid; no item is in flight.

module binary_to_decimal_ascii_core
  import bda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] digit_char_o,
  output logic [POS_W-1:0]  digit_position_o,
  output logic              last_o
);

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  started_q, started_d;
  logic                  ovf_q, ovf_d;

  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic [POS_W-1:0]      opos_q, opos_d;
  logic                  last_q, last_d;

  logic [BCD_BITS-1:0]   bcd_adj;
  logic [3:0]            top_digit;
  logic                  in_take;
  logic                  out_free;
  logic                  skip;

  // Add-three correction on every digit lane before the shift.
  always_comb begin
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BCD_BITS-1 -: 4];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A leading zero is dropped unless high digits were lost to truncation,
  // in which case all digits of the register are shown.
  assign skip = !started_q && !ovf_q && (top_digit == 4'd0) && (rem_q > REM_W'(1));

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    started_d   = started_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    opos_d      = opos_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          bin_d     = value_i[VALUE_BITS-1:0];
          bcd_d     = '0;
          cnt_d     = CNT_W'(VALUE_BITS - 1);
          rem_d     = REM_W'(MAX_DIGITS);
          pos_d     = '0;
          started_d = 1'b0;
          ovf_d     = 1'b0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
        ovf_d = ovf_q || bcd_adj[BCD_BITS-1];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          bcd_d = {bcd_q[BCD_BITS-5:0], 4'd0};
          rem_d = rem_q - REM_W'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = {ASCII_ZERO_HI, top_digit};
          opos_d      = pos_q;
          last_d      = (rem_q == REM_W'(1));
          bcd_d       = {bcd_q[BCD_BITS-5:0], 4'd0};
          rem_d       = rem_q - REM_W'(1);
          pos_d       = pos_q + POS_W'(1);
          started_d   = 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    pos_q     <= pos_d;
    started_q <= started_d;
    ovf_q     <= ovf_d;
    char_q    <= char_d;
    opos_q    <= opos_d;
    last_q    <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign digit_char_o     = char_q;
  assign digit_position_o = opos_q;
  assign last_o           = last_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for binary_to_decimal_ascii_core.
// It sends numbers, predicts the ASCII digit items of each one and checks every digit;
// it depends on bda_pkg and the core module.

module testbench;
  import bda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic              last;
  } digit_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHAR_W-1:0] digit_char_o;
  logic [POS_W-1:0]  digit_position_o;
  logic              last_o;

  digit_t pending_digits[$];
  int     error_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  binary_to_decimal_ascii_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_char_o     (digit_char_o),
    .digit_position_o (digit_position_o),
    .last_o           (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("Timeout at %0t", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // Splits the number into decimal digits and queues them most significant first.
  function automatic void predict_digits(input logic [31:0] number);
    logic [3:0]  lsd_first[MAX_DIGITS];
    logic [31:0] rest;
    int          count;
    digit_t      d;
    rest  = number;
    count = 0;
    do begin
      lsd_first[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      d.char_code = {ASCII_ZERO_HI, lsd_first[count - 1 - k]};
      d.position  = POS_W'(k);
      d.last      = (k == count - 1);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic void report_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endfunction

  // The previous item, if any, was accepted at the current edge; valid stays high
  // unless an idle gap is chosen, so it is never lowered and raised in one step.
  task automatic send_value(input logic [31:0] number);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    value_i    <= number;
    do @(posedge clk_i); while (in_stall_o);
    predict_digits(number);
  endtask

  // Picks a digit count first for three values in four so that every length shows up.
  task automatic send_random_values(input int n);
    int          ndig;
    logic [31:0] lo;
    logic [31:0] hi;
    longint      p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_value($urandom);
      end else begin
        ndig = $urandom_range(1, MAX_DIGITS);
        p = 1;
        for (int j = 1; j < ndig; j++) p = p * 10;
        lo = (ndig == 1) ? 32'd0 : 32'(p);
        hi = (p * 10 - 1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p * 10 - 1);
        send_value($urandom_range(hi, lo));
      end
    end
  endtask

  task automatic test_edge_values();
    logic [31:0] edge_values[$];
    longint      p;
    edge_values = '{32'd0, 32'd1, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, 32'd4000000000};
    p = 10;
    for (int j = 1; j < MAX_DIGITS; j++) begin
      edge_values.push_back(32'(p));
      edge_values.push_back(32'(p - 1));
      p = p * 10;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (edge_values[i]) send_value(edge_values[i]);
  endtask

  task automatic test_steady_stream();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_values(112);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    send_random_values(112);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    send_random_values(112);
  endtask

  task automatic test_both_sides_idle();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    send_random_values(112);
  endtask

  always @(posedge clk_i) begin : check_digits
    digit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit item, expected none, actual char %0d pos %0d last %0d",
                 $time, digit_char_o, digit_position_o, last_o);
        error_count++;
      end else begin
        want = pending_digits.pop_front();
        if (digit_char_o !== want.char_code)
          report_mismatch("digit_char", want.char_code, digit_char_o);
        if (digit_position_o !== want.position)
          report_mismatch("digit_position", want.position, digit_position_o);
        if (last_o !== want.last)
          report_mismatch("last", want.last, last_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    // Leave room for any stray digit after the last expected one.
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
